### hdl/sampled_rotate_hash_defines.svh
// Assertion helpers for the top-level design file.
`ifndef SAMPLED_ROTATE_HASH_DEFINES_SVH
`define SAMPLED_ROTATE_HASH_DEFINES_SVH

// Same-cycle implication, sampled on clk and idle during reset.
`define SRH_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sampled_rotate_hash: same-cycle check failed");

// Next-cycle implication, sampled on clk and idle during reset.
`define SRH_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sampled_rotate_hash: next-cycle check failed");

`endif

### hdl/srh_pkg.sv
package srh_pkg;

    localparam int WORD_W            = 32;
    localparam int LEN_IN_W          = 21;
    localparam int ROWS_W            = 6;
    localparam int CFG_IDX_W         = 1;
    localparam int CFG_DATA_W        = 6;
    localparam int DEFAULT_MAX_WORDS = 1048576;
    localparam int QUEUE_DEPTH       = 2;
    localparam int ROT_MSB           = 'h1F;
    localparam int WIN_WORDS         = 4;
    localparam int WIN_LAST          = 3;

    localparam logic [CFG_IDX_W-1:0] REG_HASH_ENABLE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_ROWS = 1'd1;

    localparam logic [ROWS_W-1:0] RESET_ROWS = 6'd5;

    typedef struct packed {
        logic first;
        logic last;
        logic sampled;
    } srh_ctl_t;

    typedef struct packed {
        logic              hash_enable;
        logic [ROWS_W-1:0] rows_eff;
    } srh_cfg_t;

    typedef struct packed {
        logic div_start;
        logic div_wait;
    } srh_status_t;

    function automatic logic [WORD_W-1:0] rotl1(input logic [WORD_W-1:0] v);
        return {v[ROT_MSB-1:0], v[ROT_MSB]};
    endfunction

    // Folds one four-word window, oldest word first.
    function automatic logic [WORD_W-1:0] fold4(
        input logic [WORD_W-1:0] h,
        input logic [WORD_W-1:0] w_oldest,
        input logic [WORD_W-1:0] w_older,
        input logic [WORD_W-1:0] w_newer,
        input logic [WORD_W-1:0] w_now
    );
        logic [WORD_W-1:0] t;
        t = rotl1(h) ^ w_oldest;
        t = rotl1(t) ^ w_older;
        t = rotl1(t) ^ w_newer;
        t = rotl1(t) ^ w_now;
        return t;
    endfunction

endpackage

### hdl/srh_queue.sv
module srh_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = srh_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             full,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign rdata = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

### hdl/srh_front.sv
module srh_front #(
    parameter int MAX_WORDS = srh_pkg::DEFAULT_MAX_WORDS
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [srh_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [srh_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  logic                                  word_valid,
    output logic                                  word_ready,
    input  logic [srh_pkg::WORD_W-1:0]            data_word,
    input  logic                                  first_word,
    input  logic [srh_pkg::LEN_IN_W-1:0]          length_words,
    input  logic                                  last_word,
    input  logic                                  q_full,
    output logic                                  q_push,
    output logic [$bits(srh_pkg::srh_ctl_t) + $clog2(MAX_WORDS + 1) + srh_pkg::WORD_W - 1:0]
                                                  q_wdata,
    output srh_pkg::srh_cfg_t                     cfg
);

    localparam int LW = $clog2(MAX_WORDS + 1);
    localparam int CW = (LW > srh_pkg::LEN_IN_W) ? LW : srh_pkg::LEN_IN_W;

    logic                        hash_enable_reg;
    logic [srh_pkg::ROWS_W-1:0]  rows_reg;
    logic [srh_pkg::ROWS_W-1:0]  rows_eff;
    logic [CW-1:0]               len_ext;
    logic [LW-1:0]               len_sat;
    logic [srh_pkg::ROWS_W+1:0]  rows_x4;
    srh_pkg::srh_ctl_t           ctl;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_enable_reg <= 1'b1;
            rows_reg        <= srh_pkg::RESET_ROWS;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                srh_pkg::REG_HASH_ENABLE: hash_enable_reg <= cfg_data[0];
                srh_pkg::REG_SAMPLE_ROWS: rows_reg        <= cfg_data;
                default: ;
            endcase
        end
    end

    // A row count of zero behaves as one.
    assign rows_eff = (rows_reg == '0) ? srh_pkg::ROWS_W'(1) : rows_reg;
    assign cfg.hash_enable = hash_enable_reg;
    assign cfg.rows_eff    = rows_eff;

    // Lengths above the supported maximum saturate.
    assign len_ext = CW'(length_words);
    assign len_sat = (len_ext > CW'(MAX_WORDS)) ? LW'(MAX_WORDS) : LW'(len_ext);
    assign rows_x4 = {rows_eff, 2'b00};

    assign ctl.first   = first_word;
    assign ctl.last    = last_word;
    assign ctl.sampled = (CW'(len_sat) >= CW'(rows_x4));

    assign word_ready = !q_full;
    assign q_push     = word_valid && word_ready;
    assign q_wdata    = {ctl, len_sat, data_word};

endmodule

### hdl/srh_div.sv
module srh_div #(
    parameter int MAX_WORDS = srh_pkg::DEFAULT_MAX_WORDS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [$clog2(MAX_WORDS + 1)-1:0]  dividend,
    input  logic [srh_pkg::ROWS_W-1:0]        divisor,
    output logic                              busy,
    output logic                              done,
    output logic [$clog2(MAX_WORDS + 1)-1:0]  quotient
);

    localparam int LW    = $clog2(MAX_WORDS + 1);
    localparam int CNT_W = $clog2(LW + 1);

    logic [LW-1:0]              acc_reg, acc_next;
    logic [srh_pkg::ROWS_W-1:0] rem_reg, rem_next;
    logic [srh_pkg::ROWS_W-1:0] div_reg;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;
    logic [srh_pkg::ROWS_W:0]   trial;
    logic                       fits;

    // One quotient bit per cycle, restoring form.
    assign trial = {rem_reg, acc_reg[LW-1]};
    assign fits  = (trial >= {1'b0, div_reg});

    always_comb
    begin
        acc_next  = acc_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            acc_next  = dividend;
            rem_next  = '0;
            cnt_next  = CNT_W'(LW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? srh_pkg::ROWS_W'(trial - {1'b0, div_reg})
                            : srh_pkg::ROWS_W'(trial);
            acc_next = {acc_reg[LW-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        rem_reg <= rem_next;
        if (start)
        begin
            div_reg <= divisor;
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = acc_reg;

endmodule

### hdl/srh_back.sv
module srh_back #(
    parameter int MAX_WORDS = srh_pkg::DEFAULT_MAX_WORDS
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  q_empty,
    input  logic [$bits(srh_pkg::srh_ctl_t) + $clog2(MAX_WORDS + 1) + srh_pkg::WORD_W - 1:0]
                                                  q_rdata,
    output logic                                  q_pop,
    input  srh_pkg::srh_cfg_t                     cfg,
    output logic [$clog2(MAX_WORDS + 1)-1:0]      div_dividend,
    input  logic                                  div_done,
    input  logic [$clog2(MAX_WORDS + 1)-1:0]      div_quotient,
    output srh_pkg::srh_status_t                  status,
    output logic                                  hash_valid,
    input  logic                                  hash_ready,
    output logic [srh_pkg::WORD_W-1:0]            hash
);

    localparam int LW     = $clog2(MAX_WORDS + 1);
    localparam int WIDX_W = LW + srh_pkg::ROWS_W;
    localparam int W      = srh_pkg::WORD_W;

    localparam logic ST_RUN = 1'b0;
    localparam logic ST_DIV = 1'b1;

    logic                       state_reg, state_next;
    logic                       opened_reg, opened_next;
    logic                       mode_reg, mode_next;
    logic [W-1:0]               hash_reg, hash_next;
    logic [WIDX_W-1:0]          widx_reg, widx_next;
    logic [WIDX_W-1:0]          target_reg, target_next;
    logic [LW-1:0]              stride_reg, stride_next;
    logic [srh_pkg::ROWS_W-1:0] wdone_reg, wdone_next;
    logic [W-1:0]               recent0_reg, recent1_reg, recent2_reg;
    logic                       out_valid_reg, out_valid_next;
    logic [W-1:0]               out_hash_reg, out_hash_next;

    logic [W-1:0]       head_word;
    logic [LW-1:0]      head_len;
    srh_pkg::srh_ctl_t  head_ctl;
    logic               first_now;
    logic               eff_mode;
    logic [W-1:0]       eff_hash;
    logic [WIDX_W-1:0]  eff_widx;
    logic [W-1:0]       fin_hash;
    logic               win_match;
    logic               slot_free;
    logic               shift_words;
    logic               div_start;

    assign head_word = q_rdata[W-1:0];
    assign head_len  = q_rdata[W+LW-1:W];
    assign head_ctl  = q_rdata[$bits(q_rdata)-1:W+LW];

    // The restart of a region applies once per head item, even if the item waits.
    assign first_now = head_ctl.first && !opened_reg;
    assign eff_mode  = first_now ? head_ctl.sampled : mode_reg;
    assign eff_hash  = first_now ? '0 : hash_reg;
    assign eff_widx  = first_now ? '0 : widx_reg;
    assign fin_hash  = eff_mode ? eff_hash : srh_pkg::rotl1(eff_hash) + head_word;

    assign win_match = mode_reg && (wdone_reg < cfg.rows_eff) && (widx_reg == target_reg);
    assign slot_free = !out_valid_reg || hash_ready;

    assign div_dividend = head_len - LW'(srh_pkg::WIN_WORDS);

    always_comb
    begin
        state_next     = state_reg;
        opened_next    = opened_reg;
        mode_next      = mode_reg;
        hash_next      = hash_reg;
        widx_next      = widx_reg;
        target_next    = target_reg;
        stride_next    = stride_reg;
        wdone_next     = wdone_reg;
        out_valid_next = out_valid_reg && !hash_ready;
        out_hash_next  = out_hash_reg;
        q_pop          = 1'b0;
        shift_words    = 1'b0;
        div_start      = 1'b0;
        case (state_reg)
            ST_RUN:
            begin
                if (!q_empty)
                begin
                    if (first_now && head_ctl.sampled)
                    begin
                        hash_next   = '0;
                        widx_next   = '0;
                        wdone_next  = '0;
                        target_next = WIDX_W'(srh_pkg::WIN_LAST);
                        mode_next   = 1'b1;
                        opened_next = 1'b1;
                        div_start   = 1'b1;
                        state_next  = ST_DIV;
                    end
                    else if (!first_now && win_match)
                    begin
                        // Several windows may end on the same word; one per cycle.
                        hash_next   = srh_pkg::fold4(hash_reg, recent2_reg, recent1_reg,
                                                     recent0_reg, head_word);
                        wdone_next  = wdone_reg + 1'b1;
                        target_next = target_reg + WIDX_W'(stride_reg);
                    end
                    else if (!head_ctl.last || slot_free)
                    begin
                        if (first_now)
                        begin
                            mode_next   = 1'b0;
                            stride_next = '0;
                            wdone_next  = '0;
                            target_next = WIDX_W'(srh_pkg::WIN_LAST);
                        end
                        hash_next   = fin_hash;
                        widx_next   = (&eff_widx) ? eff_widx : eff_widx + 1'b1;
                        shift_words = 1'b1;
                        opened_next = 1'b0;
                        q_pop       = 1'b1;
                        if (head_ctl.last)
                        begin
                            out_valid_next = 1'b1;
                            out_hash_next  = cfg.hash_enable ? fin_hash : '0;
                        end
                    end
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    stride_next = div_quotient;
                    state_next  = ST_RUN;
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_RUN;
            opened_reg    <= 1'b0;
            mode_reg      <= 1'b0;
            hash_reg      <= '0;
            widx_reg      <= '0;
            target_reg    <= WIDX_W'(srh_pkg::WIN_LAST);
            stride_reg    <= '0;
            wdone_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            opened_reg    <= opened_next;
            mode_reg      <= mode_next;
            hash_reg      <= hash_next;
            widx_reg      <= widx_next;
            target_reg    <= target_next;
            stride_reg    <= stride_next;
            wdone_reg     <= wdone_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_hash_reg <= out_hash_next;
        if (shift_words)
        begin
            recent2_reg <= recent1_reg;
            recent1_reg <= recent0_reg;
            recent0_reg <= head_word;
        end
    end

    assign status.div_start = div_start;
    assign status.div_wait  = (state_reg == ST_DIV);
    assign hash_valid       = out_valid_reg;
    assign hash             = out_hash_reg;

endmodule

### hdl/sampled_rotate_hash.sv
// Channel   Direction  Handshake               Payload
// word      in         word_valid/word_ready   data_word, first_word, length_words, last_word
// hash      out        hash_valid/hash_ready   hash
// cfg       in         cfg_valid/cfg_ready     cfg_index, cfg_data
//
// Words that fold no sampled window stream through the back end at one per cycle, but a last
// word waits for a free output register. Each sampled window that ends on a word holds that
// word for its fold. The first word of a sampled region waits for the serial stride divider.
// Reset is asynchronous and clears all control state; the three-word history is not reset.
// A two-entry queue sits between the input and the back end, and the result sits in an
// output register, so either side may stall without stopping the other at once.
`include "sampled_rotate_hash_defines.svh"

module sampled_rotate_hash #(
    parameter int MAX_WORDS = srh_pkg::DEFAULT_MAX_WORDS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [srh_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [srh_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           word_valid,
    output logic                           word_ready,
    input  logic [srh_pkg::WORD_W-1:0]     data_word,
    input  logic                           first_word,
    input  logic [srh_pkg::LEN_IN_W-1:0]   length_words,
    input  logic                           last_word,
    output logic                           hash_valid,
    input  logic                           hash_ready,
    output logic [srh_pkg::WORD_W-1:0]     hash
);

    localparam int LW = $clog2(MAX_WORDS + 1);
    localparam int QW = $bits(srh_pkg::srh_ctl_t) + LW + srh_pkg::WORD_W;

    logic                 q_push;
    logic                 q_pop;
    logic                 q_full;
    logic                 q_empty;
    logic [QW-1:0]        q_wdata;
    logic [QW-1:0]        q_rdata;
    srh_pkg::srh_cfg_t    cfg;
    srh_pkg::srh_status_t status;
    logic [LW-1:0]        div_dividend;
    logic [LW-1:0]        div_quotient;
    logic                 div_busy;
    logic                 div_done;

    srh_front #(
        .MAX_WORDS (MAX_WORDS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .word_valid   (word_valid),
        .word_ready   (word_ready),
        .data_word    (data_word),
        .first_word   (first_word),
        .length_words (length_words),
        .last_word    (last_word),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_wdata      (q_wdata),
        .cfg          (cfg)
    );

    srh_queue #(
        .WIDTH (QW),
        .DEPTH (srh_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .pop   (q_pop),
        .rdata (q_rdata),
        .full  (q_full),
        .empty (q_empty)
    );

    srh_div #(
        .MAX_WORDS (MAX_WORDS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (status.div_start),
        .dividend (div_dividend),
        .divisor  (cfg.rows_eff),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quotient)
    );

    srh_back #(
        .MAX_WORDS (MAX_WORDS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (q_empty),
        .q_rdata      (q_rdata),
        .q_pop        (q_pop),
        .cfg          (cfg),
        .div_dividend (div_dividend),
        .div_done     (div_done),
        .div_quotient (div_quotient),
        .status       (status),
        .hash_valid   (hash_valid),
        .hash_ready   (hash_ready),
        .hash         (hash)
    );

    // The back end only takes items that the queue holds.
    `SRH_ASSERT_NOW(a_pop_not_empty, q_pop, !q_empty)
    // The divider only reports a stride while the back end waits for one.
    `SRH_ASSERT_NOW(a_done_while_waiting, div_done, status.div_wait)
    // A divide is never launched over one still running, and it starts at once.
    `SRH_ASSERT_NEXT(a_start_runs, status.div_start, div_busy && status.div_wait)

endmodule
